// ----- design/i2cse_pkg.sv -----
// Shared package for the I2C status event sequencer.
// Holds queue sizing constants, operation, status and acknowledge codes,
// the control structs passed between modules and the pointer helpers.
package i2cse_pkg;

    // Queue sizing; pointer and count widths follow from the depth.
    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths of the stream payloads.
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 5;
    localparam int LEVEL_W  = 9;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_STATUS  = 2'd0,
        OP_PUSH    = 2'd1,
        OP_SET_LEN = 2'd2,
        OP_POP     = 2'd3
    } op_t;

    // Bus status codes, renumbered as the raw status divided by eight.
    typedef enum logic [STATUS_W-1:0] {
        ST_BUS_ERR       = 5'd0,
        ST_START         = 5'd1,
        ST_RSTART        = 5'd2,
        ST_AW_ACK        = 5'd3,
        ST_AW_NACK       = 5'd4,
        ST_CTX_ACK       = 5'd5,
        ST_CTX_NACK      = 5'd6,
        ST_ARB_LOST      = 5'd7,
        ST_AR_ACK        = 5'd8,
        ST_AR_NACK       = 5'd9,
        ST_CRX_ACK       = 5'd10,
        ST_CRX_NACK      = 5'd11,
        ST_OWN_AW        = 5'd12,
        ST_ARB_OWN_AW    = 5'd13,
        ST_GCALL         = 5'd14,
        ST_ARB_GCALL     = 5'd15,
        ST_PRX_ACK       = 5'd16,
        ST_PRX_NACK      = 5'd17,
        ST_GRX_ACK       = 5'd18,
        ST_GRX_NACK      = 5'd19,
        ST_STOP_RSTART   = 5'd20,
        ST_OWN_AR        = 5'd21,
        ST_ARB_OWN_AR    = 5'd22,
        ST_PTX_ACK       = 5'd23,
        ST_PTX_NACK      = 5'd24,
        ST_LAST_ACK      = 5'd25
    } status_t;

    typedef enum logic [1:0] {
        ACK_KEEP = 2'd0,
        ACK_ON   = 2'd1,
        ACK_OFF  = 2'd2
    } ack_t;

    // Decision for one item, produced in the cycle the item is taken.
    typedef struct packed {
        logic               wv;
        logic               take;
        ack_t               ack;
        logic               stop;
        logic               start;
        logic               clr;
        logic               rv;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
        logic               ovf;
    } dec_t;

    // One queue memory access request.
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } ram_req_t;

    // Head plus count, modulo the queue depth (count below the depth).
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [PTR_W:0]   cnt);
        logic [PTR_W:0] sum;
        sum = {1'b0, ptr} + cnt;
        if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Pointer increment with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

endpackage

// ----- design/i2cse_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module i2cse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when not enabled.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/i2cse_ctrl.sv -----
// Queue pointers, receive length counter and status decode.
// Issues the queue memory accesses for each item; depends on i2cse_pkg.
module i2cse_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_accept,
    input  i2cse_pkg::op_t                 item_op,
    input  logic [i2cse_pkg::STATUS_W-1:0] item_status,
    input  logic [i2cse_pkg::BYTE_W-1:0]   item_bus_data,
    input  logic [i2cse_pkg::BYTE_W-1:0]   item_host_value,
    output i2cse_pkg::dec_t                dec,
    output i2cse_pkg::ram_req_t            tx_req,
    output i2cse_pkg::ram_req_t            rx_req
);
    import i2cse_pkg::*;

    logic [PTR_W-1:0]  tx_head_reg, tx_head_next;
    logic [CNT_W-1:0]  tx_count_reg, tx_count_next;
    logic [PTR_W-1:0]  rx_head_reg, rx_head_next;
    logic [CNT_W-1:0]  rx_count_reg, rx_count_next;
    logic [BYTE_W-1:0] rx_rem_reg, rx_rem_next;

    logic              tx_empty, tx_full, rx_full;
    logic              do_take, do_put;
    logic [CNT_W-1:0]  rx_count_put;
    logic [BYTE_W-1:0] rem_dec;

    assign tx_empty     = (tx_count_reg == '0);
    assign tx_full      = (tx_count_reg == CNT_W'(QUEUE_DEPTH));
    assign rx_full      = (rx_count_reg == CNT_W'(QUEUE_DEPTH));
    assign rx_count_put = rx_full ? rx_count_reg : rx_count_reg + 1'b1;
    assign rem_dec      = rx_rem_reg - 1'b1;

    // Decode the item and work out the next queue state.
    always_comb begin
        tx_head_next  = tx_head_reg;
        tx_count_next = tx_count_reg;
        rx_head_next  = rx_head_reg;
        rx_count_next = rx_count_reg;
        rx_rem_next   = rx_rem_reg;
        dec           = '0;
        do_take       = 1'b0;
        do_put        = 1'b0;

        tx_req.we    = 1'b0;
        tx_req.waddr = wrap_add(tx_head_reg, (PTR_W+1)'(tx_count_reg));
        tx_req.wdata = item_host_value;
        tx_req.re    = 1'b0;
        tx_req.raddr = tx_head_reg;
        rx_req.we    = 1'b0;
        rx_req.waddr = wrap_add(rx_head_reg, (PTR_W+1)'(rx_count_reg));
        rx_req.wdata = item_bus_data;
        rx_req.re    = 1'b0;
        rx_req.raddr = rx_head_reg;

        if (item_accept) begin
            unique case (item_op)
                OP_STATUS: begin
                    dec.clr = 1'b1;
                    unique case (item_status) inside
                        ST_CTX_ACK: begin
                            dec.ack = ACK_ON;
                            if (tx_empty) begin
                                dec.stop = 1'b1;
                            end else begin
                                do_take = 1'b1;
                            end
                        end
                        ST_START, ST_RSTART, ST_AW_ACK: begin
                            if (!tx_empty) begin
                                do_take = 1'b1;
                                dec.ack = ACK_ON;
                            end
                        end
                        ST_BUS_ERR, ST_AW_NACK, ST_CTX_NACK, ST_AR_NACK: begin
                            dec.ack  = ACK_ON;
                            dec.stop = 1'b1;
                        end
                        ST_ARB_LOST, ST_ARB_OWN_AW, ST_ARB_GCALL, ST_ARB_OWN_AR: begin
                            dec.ack   = ACK_ON;
                            dec.start = 1'b1;
                        end
                        ST_AR_ACK, ST_OWN_AW, ST_GCALL, ST_PRX_NACK, ST_GRX_NACK,
                        ST_STOP_RSTART, ST_PTX_NACK, ST_LAST_ACK: begin
                            dec.ack = ACK_ON;
                        end
                        ST_CRX_ACK: begin
                            do_put      = 1'b1;
                            rx_rem_next = rem_dec;
                            dec.ack     = (rem_dec == '0) ? ACK_OFF : ACK_ON;
                        end
                        ST_CRX_NACK: begin
                            do_put   = 1'b1;
                            dec.ack  = ACK_ON;
                            dec.stop = 1'b1;
                        end
                        ST_PRX_ACK: begin
                            do_put  = 1'b1;
                            dec.ack = (32'(rx_count_put) == 32'(rx_rem_reg)) ? ACK_OFF
                                                                              : ACK_ON;
                        end
                        ST_GRX_ACK: begin
                            do_put  = 1'b1;
                            dec.ack = ACK_OFF;
                        end
                        ST_OWN_AR, ST_PTX_ACK: begin
                            // Empty queue sends the default byte instead.
                            dec.wv  = 1'b1;
                            dec.ack = ACK_ON;
                            do_take = !tx_empty;
                        end
                        default: begin
                            // Unused codes only clear the interrupt.
                        end
                    endcase
                end
                OP_PUSH: begin
                    if (tx_full) begin
                        dec.ovf = 1'b1;
                    end else begin
                        tx_req.we     = 1'b1;
                        tx_count_next = tx_count_reg + 1'b1;
                    end
                end
                OP_SET_LEN: begin
                    rx_rem_next = item_host_value;
                end
                OP_POP: begin
                    if (rx_count_reg != '0) begin
                        dec.rv        = 1'b1;
                        rx_req.re     = 1'b1;
                        rx_head_next  = ptr_inc(rx_head_reg);
                        rx_count_next = rx_count_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Take the head of the transmit queue.
        if (do_take) begin
            dec.wv        = 1'b1;
            dec.take      = 1'b1;
            tx_req.re     = 1'b1;
            tx_head_next  = ptr_inc(tx_head_reg);
            tx_count_next = tx_count_reg - 1'b1;
        end

        // Store a received byte, or flag it dropped when the queue is full.
        if (do_put) begin
            if (rx_full) begin
                dec.ovf = 1'b1;
            end else begin
                rx_req.we     = 1'b1;
                rx_count_next = rx_count_reg + 1'b1;
            end
        end

        dec.tx_level = LEVEL_W'(tx_count_next);
        dec.rx_level = LEVEL_W'(rx_count_next);
    end

    // Queue state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_head_reg  <= '0;
            tx_count_reg <= '0;
            rx_head_reg  <= '0;
            rx_count_reg <= '0;
            rx_rem_reg   <= '0;
        end else begin
            tx_head_reg  <= tx_head_next;
            tx_count_reg <= tx_count_next;
            rx_head_reg  <= rx_head_next;
            rx_count_reg <= rx_count_next;
            rx_rem_reg   <= rx_rem_next;
        end
    end

`ifndef ASSERT_OFF
    // Fill counts never pass the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tx_count_reg <= CNT_W'(QUEUE_DEPTH)) && (rx_count_reg <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    // A transmit read is only issued while the queue holds a byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tx_req.re |-> !tx_empty && !tx_req.we)
        else $error("transmit read from empty queue");

    // An accepted push to a queue with room grows the count by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept && item_op == OP_PUSH && !tx_full
        |=> tx_count_reg == $past(tx_count_reg) + 1'b1)
        else $error("push did not advance transmit count");
`endif

endmodule

// ----- design/i2c_status_event_sequencer_top.sv -----
// An input beat passes the item stage register, then the output register.
// Throughput: one item per cycle unless the output stalls; per item at most
// one queue memory access, whose registered read sets the two-stage pipeline.
// Reset (aresetn low, synchronous): queues empty, receive length zero,
// default transmit byte zero, both channels idle. No clearing pass is needed.
// Top level of the I2C status event sequencer; depends on i2cse_pkg,
// i2cse_ctrl and i2cse_ram.
module i2c_status_event_sequencer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write: default transmit byte.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [i2cse_pkg::BYTE_W-1:0]   cfg_data,
    // Input beats.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // status[4:0], bus_data[12:5], host_value[20:13], zero[23:21]
    input  logic [i2cse_pkg::S_DATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [i2cse_pkg::OP_W-1:0]     s_tuser,
    // Result beats.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // write_valid[0], write_byte[8:1], ack_action[10:9], send_stop[11],
    // send_start[12], clear_interrupt[13], rx_valid[14], rx_byte[22:15],
    // tx_level[31:23], rx_level[40:32], overflow[41], zero[47:42]
    output logic [i2cse_pkg::M_DATA_W-1:0] m_tdata
);
    import i2cse_pkg::*;

    logic              accept;
    logic              s1_adv;
    dec_t              dec;
    ram_req_t          tx_req, rx_req;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    logic [BYTE_W-1:0]   dflt_reg, dflt_next;
    logic                s1_valid_reg, s1_valid_next;
    dec_t                s1_dec_reg, s1_dec_next;
    logic [BYTE_W-1:0]   s1_wbc_reg, s1_wbc_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [BYTE_W-1:0]   wbyte, rbyte;

    // Handshakes: the item stage advances whenever the output register frees.
    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    i2cse_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_accept     (accept),
        .item_op         (op_t'(s_tuser)),
        .item_status     (s_tdata[4:0]),
        .item_bus_data   (s_tdata[12:5]),
        .item_host_value (s_tdata[20:13]),
        .dec             (dec),
        .tx_req          (tx_req),
        .rx_req          (rx_req)
    );

    i2cse_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_req.we),
        .waddr (tx_req.waddr),
        .wdata (tx_req.wdata),
        .re    (tx_req.re),
        .raddr (tx_req.raddr),
        .rdata (tx_rdata)
    );

    i2cse_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_req.we),
        .waddr (rx_req.waddr),
        .wdata (rx_req.wdata),
        .re    (rx_req.re),
        .raddr (rx_req.raddr),
        .rdata (rx_rdata)
    );

    // Item stage, configuration and output register next values.
    always_comb begin
        dflt_next     = cfg_valid ? cfg_data : dflt_reg;
        s1_valid_next = accept || (s1_valid_reg && !s1_adv);
        s1_dec_next   = accept ? dec : s1_dec_reg;
        s1_wbc_next   = s1_wbc_reg;
        if (accept) begin
            s1_wbc_next = (dec.wv && !dec.take) ? dflt_reg : '0;
        end

        // Memory read data joins the decision as the item leaves the stage.
        wbyte = s1_dec_reg.take ? tx_rdata : s1_wbc_reg;
        rbyte = s1_dec_reg.rv ? rx_rdata : '0;

        m_valid_next = s1_adv || (m_valid_reg && !m_tready);
        m_data_next  = m_data_reg;
        if (s1_adv) begin
            m_data_next = {6'b0, s1_dec_reg.ovf, s1_dec_reg.rx_level,
                           s1_dec_reg.tx_level, rbyte, s1_dec_reg.rv,
                           s1_dec_reg.clr, s1_dec_reg.start, s1_dec_reg.stop,
                           s1_dec_reg.ack, wbyte, s1_dec_reg.wv};
        end
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            dflt_reg     <= dflt_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        s1_dec_reg <= s1_dec_next;
        s1_wbc_reg <= s1_wbc_next;
        m_data_reg <= m_data_next;
    end

`ifndef ASSERT_OFF
    // A full item stage behind a stalled output must refuse new beats.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while pipeline is blocked");

    // An item leaving the stage is offered on the output next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_valid_reg)
        else $error("advanced item not offered");

    // A result beat that is held off stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for i2c_status_event_sequencer_top.
// Depends on i2cse_pkg and the sequencer RTL; a scoreboard class predicts each result beat.
module tb_top;
    import i2cse_pkg::*;

    localparam int STALL_LIMIT = 3000;

    // One result beat, laid out as m_tdata[41:0] with write_valid at bit 0.
    typedef struct packed {
        logic               ovf;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic [BYTE_W-1:0]  rx_byte;
        logic               rv;
        logic               clr;
        logic               start;
        logic               stop;
        ack_t               ack;
        logic [BYTE_W-1:0]  wbyte;
        logic               wv;
    } seq_result_t;

    // Scoreboard: its own copy of both queues, the receive count and the default byte.
    class sequencer_scoreboard;
        logic [BYTE_W-1:0] tx_mem [QUEUE_DEPTH];
        logic [BYTE_W-1:0] rx_mem [QUEUE_DEPTH];
        logic [PTR_W-1:0]  tx_head;
        logic [PTR_W-1:0]  rx_head;
        logic [CNT_W-1:0]  tx_cnt;
        logic [CNT_W-1:0]  rx_cnt;
        logic [BYTE_W-1:0] rx_left;
        logic [BYTE_W-1:0] dflt_byte;
        seq_result_t       pending_actions[$];
        int                errors;
        int                beat_no;

        function new();
            tx_head   = '0;
            rx_head   = '0;
            tx_cnt    = '0;
            rx_cnt    = '0;
            rx_left   = '0;
            dflt_byte = '0;
            errors    = 0;
            beat_no   = 0;
        endfunction

        function void set_default(logic [BYTE_W-1:0] b);
            dflt_byte = b;
        endfunction

        function int pending();
            return pending_actions.size();
        endfunction

        // Oldest transmit byte; only called with a non-empty queue.
        function logic [BYTE_W-1:0] take_tx_byte();
            logic [BYTE_W-1:0] b;
            b = tx_mem[tx_head];
            tx_head++;
            tx_cnt--;
            return b;
        endfunction

        // Append a received byte; returns 1 when it was dropped.
        function logic store_rx_byte(logic [BYTE_W-1:0] b);
            if (rx_cnt >= CNT_W'(QUEUE_DEPTH)) begin
                return 1'b1;
            end
            rx_mem[rx_head + rx_cnt[PTR_W-1:0]] = b;
            rx_cnt++;
            return 1'b0;
        endfunction

        // Work out the result of one accepted input beat and queue it.
        function void note_item(op_t op, logic [STATUS_W-1:0] st,
                                logic [BYTE_W-1:0] bus_byte, logic [BYTE_W-1:0] hv);
            seq_result_t r;
            r = '0;
            r.ack = ACK_KEEP;
            case (op)
                OP_STATUS: begin
                    r.clr = 1'b1;
                    case (st)
                        ST_START, ST_RSTART, ST_AW_ACK, ST_CTX_ACK: begin
                            // Controller transmit with nothing queued ends the transfer.
                            if (st == ST_CTX_ACK && tx_cnt == 0) begin
                                r.ack  = ACK_ON;
                                r.stop = 1'b1;
                            end else if (tx_cnt != 0) begin
                                r.wv    = 1'b1;
                                r.wbyte = take_tx_byte();
                                r.ack   = ACK_ON;
                            end
                        end
                        ST_BUS_ERR, ST_AW_NACK, ST_CTX_NACK, ST_AR_NACK: begin
                            r.ack  = ACK_ON;
                            r.stop = 1'b1;
                        end
                        ST_ARB_LOST, ST_ARB_OWN_AW, ST_ARB_GCALL, ST_ARB_OWN_AR: begin
                            r.ack   = ACK_ON;
                            r.start = 1'b1;
                        end
                        ST_AR_ACK, ST_OWN_AW, ST_GCALL, ST_PRX_NACK, ST_GRX_NACK,
                        ST_STOP_RSTART, ST_PTX_NACK, ST_LAST_ACK: begin
                            r.ack = ACK_ON;
                        end
                        ST_CRX_ACK: begin
                            r.ovf   = store_rx_byte(bus_byte);
                            rx_left = rx_left - 1'b1;
                            r.ack   = (rx_left == 0) ? ACK_OFF : ACK_ON;
                        end
                        ST_CRX_NACK: begin
                            r.ovf  = store_rx_byte(bus_byte);
                            r.ack  = ACK_ON;
                            r.stop = 1'b1;
                        end
                        ST_PRX_ACK: begin
                            r.ovf = store_rx_byte(bus_byte);
                            r.ack = (rx_cnt == {1'b0, rx_left}) ? ACK_OFF : ACK_ON;
                        end
                        ST_GRX_ACK: begin
                            r.ovf = store_rx_byte(bus_byte);
                            r.ack = ACK_OFF;
                        end
                        ST_OWN_AR, ST_PTX_ACK: begin
                            // Peripheral transmit falls back to the default byte.
                            r.wv    = 1'b1;
                            r.wbyte = (tx_cnt == 0) ? dflt_byte : take_tx_byte();
                            r.ack   = ACK_ON;
                        end
                        default: begin
                        end
                    endcase
                end
                OP_PUSH: begin
                    if (tx_cnt >= CNT_W'(QUEUE_DEPTH)) begin
                        r.ovf = 1'b1;
                    end else begin
                        tx_mem[tx_head + tx_cnt[PTR_W-1:0]] = hv;
                        tx_cnt++;
                    end
                end
                OP_SET_LEN: begin
                    rx_left = hv;
                end
                default: begin
                    if (rx_cnt != 0) begin
                        r.rv      = 1'b1;
                        r.rx_byte = rx_mem[rx_head];
                        rx_head++;
                        rx_cnt--;
                    end
                end
            endcase
            r.tx_level = tx_cnt;
            r.rx_level = rx_cnt;
            pending_actions.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 40) begin
                $display("%0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        task cmp(string name, logic [8:0] got, logic [8:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                 beat_no, name, got, want));
            end
        endtask

        // Compare one result beat with the oldest expectation, field by field.
        task check_result(logic [M_DATA_W-1:0] beat);
            seq_result_t got;
            seq_result_t want;
            if (pending_actions.size() == 0) begin
                report($sformatf("result %0d arrived with no item outstanding", beat_no));
                beat_no++;
                return;
            end
            want = pending_actions.pop_front();
            got  = seq_result_t'(beat[41:0]);
            cmp("write_valid", 9'(got.wv), 9'(want.wv));
            cmp("write_byte", 9'(got.wbyte), 9'(want.wbyte));
            cmp("ack_action", {7'b0, got.ack}, {7'b0, want.ack});
            cmp("send_stop", 9'(got.stop), 9'(want.stop));
            cmp("send_start", 9'(got.start), 9'(want.start));
            cmp("clear_interrupt", 9'(got.clr), 9'(want.clr));
            cmp("rx_valid", 9'(got.rv), 9'(want.rv));
            cmp("rx_byte", 9'(got.rx_byte), 9'(want.rx_byte));
            cmp("tx_level", got.tx_level, want.tx_level);
            cmp("rx_level", got.rx_level, want.rx_level);
            cmp("overflow", 9'(got.ovf), 9'(want.ovf));
            cmp("pad", {3'b0, beat[47:42]}, 9'd0);
            beat_no++;
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [BYTE_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    sequencer_scoreboard sb;
    bit quiet;
    bit long_hold_req;
    int items_sent;
    int stall_left;
    int idle_cycles;

    i2c_status_event_sequencer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Monitor and watchdog: every handshake is seen with pre-edge values.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_item(op_t'(s_tuser), s_tdata[4:0], s_tdata[12:5], s_tdata[20:13]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (cfg_valid && cfg_ready) begin
                sb.set_default(cfg_data);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = 399;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Random field values at the width of their fields.
    function automatic logic [BYTE_W-1:0] rnd_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [STATUS_W-1:0] rnd_st();
        return STATUS_W'($urandom);
    endfunction

    // Offer one input beat, after an optional idle burst, and wait until it is taken.
    task automatic send(op_t op, logic [STATUS_W-1:0] st,
                        logic [BYTE_W-1:0] bus_byte, logic [BYTE_W-1:0] hv);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, hv, bus_byte, st};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering beats and let every expected result come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_default(logic [BYTE_W-1:0] b);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One bus transaction with random content, or a short run of random noise.
    task automatic run_transfer();
        int kind;
        int n;
        bit gcall;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(0, 5);
        case (kind)
            0, 1: begin
                // Controller write: queue the bytes, then clock them out.
                repeat (n) send(OP_PUSH, rnd_st(), rnd_byte(), rnd_byte());
                send(OP_STATUS, $urandom_range(0, 1) ? ST_START : ST_RSTART,
                     rnd_byte(), rnd_byte());
                if ($urandom_range(0, 5) == 0) begin
                    send(OP_STATUS, ST_AW_NACK, rnd_byte(), rnd_byte());
                end else begin
                    send(OP_STATUS, ST_AW_ACK, rnd_byte(), rnd_byte());
                    repeat (n) send(OP_STATUS, ST_CTX_ACK, rnd_byte(), rnd_byte());
                    send(OP_STATUS, $urandom_range(0, 3) == 0 ? ST_CTX_NACK : ST_CTX_ACK,
                         rnd_byte(), rnd_byte());
                end
            end
            2, 3: begin
                // Controller read of n+2 bytes (length n+1), then the host drains them.
                send(OP_SET_LEN, rnd_st(), rnd_byte(), BYTE_W'(n + 1));
                send(OP_STATUS, ST_START, rnd_byte(), rnd_byte());
                if ($urandom_range(0, 5) == 0) begin
                    send(OP_STATUS, ST_AR_NACK, rnd_byte(), rnd_byte());
                end else begin
                    send(OP_STATUS, ST_AR_ACK, rnd_byte(), rnd_byte());
                    repeat (n + 1) send(OP_STATUS, ST_CRX_ACK, rnd_byte(), rnd_byte());
                    send(OP_STATUS, ST_CRX_NACK, rnd_byte(), rnd_byte());
                end
                repeat (n + 2) send(OP_POP, rnd_st(), rnd_byte(), rnd_byte());
            end
            4, 5: begin
                // Peripheral receive, addressed directly or by general call.
                gcall = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1)) begin
                    send(OP_SET_LEN, rnd_st(), rnd_byte(), BYTE_W'(n));
                end
                case ($urandom_range(0, 3))
                    0: send(OP_STATUS, ST_OWN_AW, rnd_byte(), rnd_byte());
                    1: send(OP_STATUS, ST_ARB_OWN_AW, rnd_byte(), rnd_byte());
                    2: send(OP_STATUS, ST_GCALL, rnd_byte(), rnd_byte());
                    default: send(OP_STATUS, ST_ARB_GCALL, rnd_byte(), rnd_byte());
                endcase
                repeat (n) send(OP_STATUS, gcall ? ST_GRX_ACK : ST_PRX_ACK,
                                rnd_byte(), rnd_byte());
                send(OP_STATUS, gcall ? ST_GRX_NACK : ST_PRX_NACK, rnd_byte(), rnd_byte());
                send(OP_STATUS, ST_STOP_RSTART, rnd_byte(), rnd_byte());
                repeat (n + 1) send(OP_POP, rnd_st(), rnd_byte(), rnd_byte());
            end
            6, 7: begin
                // Peripheral transmit; may run past the queued bytes.
                repeat ($urandom_range(0, 4)) send(OP_PUSH, rnd_st(), rnd_byte(), rnd_byte());
                send(OP_STATUS, $urandom_range(0, 1) ? ST_OWN_AR : ST_ARB_OWN_AR,
                     rnd_byte(), rnd_byte());
                repeat (n) send(OP_STATUS, ST_PTX_ACK, rnd_byte(), rnd_byte());
                send(OP_STATUS, $urandom_range(0, 1) ? ST_PTX_NACK : ST_LAST_ACK,
                     rnd_byte(), rnd_byte());
            end
            default: begin
                repeat (n + 1) send(op_t'($urandom_range(0, 3)),
                                    STATUS_W'($urandom_range(0, 31)),
                                    rnd_byte(), rnd_byte());
            end
        endcase
    endtask

    initial begin
        sb = new();
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, receive length wrap, empty queues, no-action code.
        write_default(8'hFF);
        send(OP_STATUS, ST_CTX_ACK, 8'h00, 8'h00);
        send(OP_STATUS, ST_OWN_AR, 8'h00, 8'h00);
        send(OP_PUSH, 5'd0, 8'h00, 8'h00);
        send(OP_PUSH, 5'd31, 8'hFF, 8'hFF);
        send(OP_PUSH, 5'd0, 8'h00, 8'h5A);
        send(OP_STATUS, ST_START, 8'h00, 8'h00);
        send(OP_STATUS, ST_RSTART, 8'h00, 8'h00);
        send(OP_STATUS, ST_AW_ACK, 8'h00, 8'h00);
        send(OP_STATUS, ST_AW_ACK, 8'h00, 8'h00);
        send(OP_SET_LEN, 5'd0, 8'h00, 8'h00);
        send(OP_STATUS, ST_CRX_ACK, 8'hFF, 8'h00);
        send(OP_SET_LEN, 5'd0, 8'h00, 8'h01);
        send(OP_STATUS, ST_CRX_ACK, 8'h00, 8'h00);
        send(OP_STATUS, ST_CRX_NACK, 8'h80, 8'h00);
        send(OP_SET_LEN, 5'd0, 8'h00, 8'h04);
        send(OP_STATUS, ST_PRX_ACK, 8'h01, 8'h00);
        send(OP_STATUS, ST_GRX_ACK, 8'h7F, 8'h00);
        repeat (6) send(OP_POP, 5'd0, 8'h00, 8'h00);
        send(OP_STATUS, 5'd31, 8'hFF, 8'hFF);
        send(OP_STATUS, ST_ARB_LOST, 8'h00, 8'h00);
        send(OP_STATUS, ST_BUS_ERR, 8'h00, 8'h00);

        // Random transactions, with one pause until the block has drained.
        write_default(8'h00);
        while (items_sent < 300) run_transfer();
        wait_idle();
        while (items_sent < 600) run_transfer();

        // Overfill the transmit queue while the result side holds off, then drain it.
        write_default(rnd_byte());
        long_hold_req = 1'b1;
        repeat (QUEUE_DEPTH + 4) send(OP_PUSH, rnd_st(), rnd_byte(), rnd_byte());
        repeat (QUEUE_DEPTH + 6) send(OP_STATUS, ST_PTX_ACK, rnd_byte(), rnd_byte());

        // Overfill the receive queue, then pop past empty.
        write_default(8'h80);
        repeat (QUEUE_DEPTH + 6) begin
            case ($urandom_range(0, 3))
                0: send(OP_STATUS, ST_CRX_ACK, rnd_byte(), rnd_byte());
                1: send(OP_STATUS, ST_CRX_NACK, rnd_byte(), rnd_byte());
                2: send(OP_STATUS, ST_PRX_ACK, rnd_byte(), rnd_byte());
                default: send(OP_STATUS, ST_GRX_ACK, rnd_byte(), rnd_byte());
            endcase
        end
        repeat (QUEUE_DEPTH + 6) send(OP_POP, rnd_st(), rnd_byte(), rnd_byte());

        // Last stretch runs back to back on both sides.
        write_default(rnd_byte());
        quiet = 1'b1;
        while (items_sent < 1900) run_transfer();
        wait_idle();
        repeat (8) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
